FILE: hdl/hnus_pkg.sv
// Shared types and constants of the HEVC unit scanner.
// Used by hnus_core and hevc_nal_unit_scanner; depends on nothing.
package hnus_pkg;

  // Sizing of counters and result fields
  localparam int POSITION_BITS = 24;
  localparam int LENGTH_BITS   = POSITION_BITS + 1;
  localparam int MAX_BUFFERS   = 256;
  localparam int BUF_CNT_BITS  = (MAX_BUFFERS > 2) ? $clog2(MAX_BUFFERS) : 1;
  localparam int BUF_NUM_BITS  = 8;
  localparam int TYPE_BITS     = 6;
  localparam int SLICE_BITS    = 32;
  localparam int CLASS_BITS    = 3;

  // Output stream packing
  localparam int OUT_RAW_BITS   = TYPE_BITS + BUF_NUM_BITS + POSITION_BITS + LENGTH_BITS
                                  + 2 * SLICE_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  // Header unit types of interest
  localparam logic [TYPE_BITS-1:0] TYPE_TRAIL = 6'h01;
  localparam logic [TYPE_BITS-1:0] TYPE_IDR   = 6'h13;
  localparam logic [TYPE_BITS-1:0] TYPE_VPS   = 6'h20;
  localparam logic [TYPE_BITS-1:0] TYPE_SPS   = 6'h21;
  localparam logic [TYPE_BITS-1:0] TYPE_PPS   = 6'h22;

  typedef enum logic [CLASS_BITS-1:0] {
    CLASS_VPS   = 3'd0,
    CLASS_SPS   = 3'd1,
    CLASS_PPS   = 3'd2,
    CLASS_IDR   = 3'd3,
    CLASS_OTHER = 3'd4,
    CLASS_NONE  = 3'd5
  } unit_class_e;

  // One input byte with its buffer markers
  typedef struct packed {
    logic       picture_end;
    logic       buffer_end;
    logic [7:0] data_byte;
  } item_t;

  // One result
  typedef struct packed {
    unit_class_e               unit_class;
    logic [TYPE_BITS-1:0]      unit_type;
    logic [BUF_NUM_BITS-1:0]   buffer_number;
    logic [POSITION_BITS-1:0]  unit_offset;
    logic [LENGTH_BITS-1:0]    unit_length;
    logic [SLICE_BITS-1:0]     slice_bytes;
    logic [SLICE_BITS-1:0]     length_prefix;
    logic                      picture_done;
    logic                      no_slice_error;
  } result_t;

endpackage

FILE: hdl/hevc_nal_unit_scanner.sv
// Top level of the HEVC unit scanner: input register, scanner core, result register.
// Depends on hnus_pkg and hnus_core.
//
// Usage:
//   The slave stream carries one byte of an encoded buffer per request; tuser
//   flags the buffer's final byte and tlast the picture's final byte (which
//   also ends the buffer). The master stream carries one result for each unit
//   that closes (at the next start code or at the buffer's end) and one more
//   at picture end, which has tlast set and holds the length prefix or the
//   no-slice error flag. A byte that closes a unit at picture end gives a
//   single result carrying both.
//   Throughput is one byte per cycle while the receiver keeps up: the per-byte step
//   is a single pass of compare and add logic between the input register and the
//   result register. An accepted byte is held in the input register and its result
//   in the result register, from which it is valid on the master side.
//   When the receiver stalls, the result waits in its register and the byte
//   behind it waits in the input register; only then does s_axis_tready drop.
//   Reset clears all scanner state, the slice total and both valid flags.
module hevc_nal_unit_scanner (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0] s_axis_tuser,  // [0] buffer_end
  input  logic       s_axis_tlast,  // picture_end
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  // [5:0] unit_type, [13:6] buffer_number, [37:14] unit_offset,
  // [62:38] unit_length, [94:63] slice_bytes, [126:95] length_prefix, [127] zero
  output logic [hnus_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  output logic [3:0] m_axis_tuser,  // [2:0] unit_class, [3] no_slice_error
  output logic       m_axis_tlast   // picture_done
);
  import hnus_pkg::*;

  logic    in_valid_q, in_valid_d;
  item_t   in_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  logic    s_fire;
  logic    advance;
  result_t step_result;
  logic    step_emit;

  // Handshake: the input register drains whenever the result register is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && step_emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q.data_byte   <= s_axis_tdata;
      in_item_q.buffer_end  <= s_axis_tuser[0];
      in_item_q.picture_end <= s_axis_tlast;
    end
    if (advance && step_emit) begin
      out_q <= step_result;
    end
  end

  hnus_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (step_result),
    .emit_o   (step_emit)
  );

  // Output packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_BITS'({out_q.length_prefix, out_q.slice_bytes,
                                          out_q.unit_length, out_q.unit_offset,
                                          out_q.buffer_number, out_q.unit_type});
  assign m_axis_tuser  = {out_q.no_slice_error, out_q.unit_class};
  assign m_axis_tlast  = out_q.picture_done;

`ifndef NO_ASSERTIONS
  // A held byte must not be overwritten while its result slot is blocked
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input register overwritten while stalled");

  // A picture-closing result with the error flag carries no length prefix
  a_error_no_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.no_slice_error) |-> (out_q.picture_done && out_q.length_prefix == '0))
    else $error("no-slice error with nonzero length prefix");
`endif

endmodule

FILE: hdl/hnus_core.sv
// Scanner state and the per-byte step: start code search, unit close, slice total.
// Depends on hnus_pkg.
module hnus_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  hnus_pkg::item_t  item_i,
  output hnus_pkg::result_t result_o,
  output logic             emit_o
);
  import hnus_pkg::*;

  logic [23:0]              window_q, window_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] offset_q, offset_d;
  logic [TYPE_BITS-1:0]     type_q, type_d;
  logic                     open_q, open_d;
  logic                     hdr_pend_q, hdr_pend_d;
  logic                     stopped_q, stopped_d;
  logic [BUF_CNT_BITS-1:0]  buf_cnt_q, buf_cnt_d;
  logic [SLICE_BITS-1:0]    slice_q, slice_d;

  logic                     buf_end;
  logic                     pic_end;
  logic                     start_hit;
  logic                     do_close;
  logic [TYPE_BITS-1:0]     hdr_type;
  logic [TYPE_BITS-1:0]     close_type;
  logic [LENGTH_BITS-1:0]   close_end;
  logic [LENGTH_BITS-1:0]   unit_len;
  unit_class_e              close_class;
  logic [SLICE_BITS:0]      slice_sum;
  logic [SLICE_BITS-1:0]    slice_new;

  function automatic unit_class_e class_of(input logic [TYPE_BITS-1:0] t);
    unit_class_e c;
    case (t)
      TYPE_VPS: c = CLASS_VPS;
      TYPE_SPS: c = CLASS_SPS;
      TYPE_PPS: c = CLASS_PPS;
      TYPE_IDR: c = CLASS_IDR;
      default:  c = CLASS_OTHER;
    endcase
    return c;
  endfunction

  // Decode of the current byte against the scanner state
  assign pic_end   = item_i.picture_end;
  assign buf_end   = item_i.buffer_end | item_i.picture_end;
  assign hdr_type  = item_i.data_byte[6:1];
  assign start_hit = !hdr_pend_q && !stopped_q && (pos_q >= POSITION_BITS'(3))
                     && (window_q == 24'h0) && (item_i.data_byte == 8'h01) && !buf_end;
  assign do_close  = open_q && (start_hit || buf_end);

  // A header byte on the buffer's last byte still names the closing unit
  assign close_type  = hdr_pend_q ? hdr_type : type_q;
  assign close_class = class_of(close_type);
  assign close_end   = start_hit ? LENGTH_BITS'(pos_q - POSITION_BITS'(3))
                                 : LENGTH_BITS'(pos_q) + LENGTH_BITS'(1);
  assign unit_len    = close_end - LENGTH_BITS'(offset_q);

  // Saturating slice byte total
  assign slice_sum = {1'b0, slice_q} + (SLICE_BITS+1)'(unit_len);
  always_comb begin
    slice_new = slice_q;
    if (do_close && (close_class == CLASS_IDR)) begin
      slice_new = slice_sum[SLICE_BITS] ? {SLICE_BITS{1'b1}} : slice_sum[SLICE_BITS-1:0];
    end
  end

  // Result fields
  always_comb begin
    result_o = '0;
    result_o.unit_class = CLASS_NONE;
    if (do_close) begin
      result_o.unit_class    = close_class;
      result_o.unit_type     = close_type;
      result_o.buffer_number = BUF_NUM_BITS'(buf_cnt_q);
      result_o.unit_offset   = offset_q;
      result_o.unit_length   = unit_len;
    end
    if (do_close || pic_end) begin
      result_o.slice_bytes = slice_new;
    end
    if (pic_end) begin
      result_o.picture_done   = 1'b1;
      result_o.no_slice_error = (slice_new == '0);
      if (slice_new >= SLICE_BITS'(4)) begin
        result_o.length_prefix = slice_new - SLICE_BITS'(4);
      end
    end
  end
  assign emit_o = do_close || pic_end;

  // Next state
  always_comb begin
    window_d   = {window_q[15:0], item_i.data_byte};
    pos_d      = pos_q;
    offset_d   = offset_q;
    type_d     = type_q;
    open_d     = open_q;
    hdr_pend_d = hdr_pend_q;
    stopped_d  = stopped_q;
    buf_cnt_d  = buf_cnt_q;
    slice_d    = slice_new;
    if (buf_end) begin
      window_d   = '0;
      pos_d      = '0;
      offset_d   = '0;
      type_d     = '0;
      open_d     = 1'b0;
      hdr_pend_d = 1'b0;
      stopped_d  = 1'b0;
      if (pic_end) begin
        buf_cnt_d = '0;
        slice_d   = '0;
      end else if (buf_cnt_q < BUF_CNT_BITS'(MAX_BUFFERS - 1)) begin
        buf_cnt_d = buf_cnt_q + BUF_CNT_BITS'(1);
      end
    end else begin
      if (pos_q != {POSITION_BITS{1'b1}}) begin
        pos_d = pos_q + POSITION_BITS'(1);
      end
      if (hdr_pend_q) begin
        type_d     = hdr_type;
        hdr_pend_d = 1'b0;
        if ((hdr_type == TYPE_IDR) || (hdr_type == TYPE_TRAIL)) begin
          stopped_d = 1'b1;
        end
      end else if (start_hit) begin
        offset_d   = pos_q - POSITION_BITS'(3);
        type_d     = '0;
        open_d     = 1'b1;
        hdr_pend_d = 1'b1;
      end
    end
  end

  // State registers, advanced once per processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      pos_q      <= '0;
      offset_q   <= '0;
      type_q     <= '0;
      open_q     <= 1'b0;
      hdr_pend_q <= 1'b0;
      stopped_q  <= 1'b0;
      buf_cnt_q  <= '0;
      slice_q    <= '0;
    end else if (step_i) begin
      window_q   <= window_d;
      pos_q      <= pos_d;
      offset_q   <= offset_d;
      type_q     <= type_d;
      open_q     <= open_d;
      hdr_pend_q <= hdr_pend_d;
      stopped_q  <= stopped_d;
      buf_cnt_q  <= buf_cnt_d;
      slice_q    <= slice_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A pending header always belongs to an open unit
  a_hdr_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_pend_q |-> open_q)
    else $error("header pending without an open unit");

  // Scanning only stops after the header of an open unit was read
  a_stop_needs_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (open_q && !hdr_pend_q))
    else $error("scan stopped in an inconsistent state");

  // The open unit's start code lies at least three bytes behind the position
  a_offset_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> ((LENGTH_BITS'(offset_q) + LENGTH_BITS'(3)) <= LENGTH_BITS'(pos_q)))
    else $error("open unit offset ahead of byte position");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the HEVC unit scanner: streams encoded bytes in, predicts
// each unit report and picture close, and checks the master stream against them.
// Depends on hnus_pkg and hevc_nal_unit_scanner.
module tb_top;
  import hnus_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata  = '0;
  logic [0:0]                s_axis_tuser  = '0;
  logic                      s_axis_tlast  = 1'b0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic [3:0]                m_axis_tuser;
  logic                      m_axis_tlast;

  // Stimulus bytes waiting to be sent and unit reports waiting to arrive
  item_t   byte_q[$];
  result_t unit_reports_q[$];
  logic [7:0] buf_bytes[$];

  int unsigned cyc = 0;
  int unsigned mismatches = 0;
  int unsigned reports_seen = 0;

  // Scanner state as predicted
  logic [23:0]              win_bytes  = '0;
  logic [POSITION_BITS-1:0] scan_pos   = '0;
  logic [POSITION_BITS-1:0] open_ofs   = '0;
  logic [TYPE_BITS-1:0]     open_kind  = '0;
  logic                     unit_live  = 1'b0;
  logic                     hdr_wait   = 1'b0;
  logic                     scan_halt  = 1'b0;
  int unsigned              buf_idx    = 0;
  logic [SLICE_BITS-1:0]    slice_sum  = '0;

  hevc_nal_unit_scanner u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  // Close the open unit at end_pos (exclusive); IDR lengths go into the slice total
  function automatic result_t close_open_unit(logic [LENGTH_BITS-1:0] end_pos);
    result_t                r;
    logic [LENGTH_BITS-1:0] len;
    logic [SLICE_BITS:0]    sum;
    r   = '0;
    len = end_pos - LENGTH_BITS'(open_ofs);
    case (open_kind)
      TYPE_VPS: r.unit_class = CLASS_VPS;
      TYPE_SPS: r.unit_class = CLASS_SPS;
      TYPE_PPS: r.unit_class = CLASS_PPS;
      TYPE_IDR: r.unit_class = CLASS_IDR;
      default:  r.unit_class = CLASS_OTHER;
    endcase
    if (r.unit_class == CLASS_IDR) begin
      sum       = {1'b0, slice_sum} + (SLICE_BITS + 1)'(len);
      slice_sum = sum[SLICE_BITS] ? '1 : sum[SLICE_BITS-1:0];
    end
    r.unit_type     = open_kind;
    r.buffer_number = buf_idx[7:0];
    r.unit_offset   = open_ofs;
    r.unit_length   = len;
    r.slice_bytes   = slice_sum;
    return r;
  endfunction

  // Advance the predicted scanner by one accepted byte
  function automatic void scan_byte(item_t it);
    logic [7:0]               b;
    logic                     pic_end;
    logic                     buf_end;
    logic [POSITION_BITS-1:0] p;
    logic                     emit;
    result_t                  r;
    b       = it.data_byte;
    pic_end = it.picture_end;
    buf_end = it.buffer_end | pic_end;
    p       = scan_pos;
    emit    = 1'b0;
    r       = '0;
    r.unit_class = CLASS_NONE;

    // header byte right after a start code, or a new start code
    if (hdr_wait) begin
      open_kind = b[6:1];
      hdr_wait  = 1'b0;
      if (open_kind == TYPE_IDR || open_kind == TYPE_TRAIL) scan_halt = 1'b1;
    end else if (!scan_halt && p >= 3 && win_bytes == '0 && b == 8'h01 && !buf_end) begin
      if (unit_live) begin
        r    = close_open_unit(LENGTH_BITS'(p - 3));
        emit = 1'b1;
      end
      open_ofs  = p - 3;
      open_kind = '0;
      unit_live = 1'b1;
      hdr_wait  = 1'b1;
    end

    win_bytes = {win_bytes[15:0], b};

    // buffer end closes the unit; picture end also closes the picture
    if (buf_end) begin
      if (unit_live) begin
        r    = close_open_unit(LENGTH_BITS'(p) + 1'b1);
        emit = 1'b1;
      end
      win_bytes = '0;
      scan_pos  = '0;
      open_ofs  = '0;
      open_kind = '0;
      unit_live = 1'b0;
      hdr_wait  = 1'b0;
      scan_halt = 1'b0;
      if (buf_idx < MAX_BUFFERS - 1) buf_idx++;
      if (pic_end) begin
        r.slice_bytes  = slice_sum;
        r.picture_done = 1'b1;
        if (slice_sum == '0) begin
          r.length_prefix  = '0;
          r.no_slice_error = 1'b1;
        end else begin
          r.length_prefix  = (slice_sum >= 4) ? slice_sum - 4 : '0;
          r.no_slice_error = 1'b0;
        end
        slice_sum = '0;
        buf_idx   = 0;
        emit      = 1'b1;
      end
    end else if (scan_pos != '1) begin
      scan_pos++;
    end

    if (emit) unit_reports_q = {unit_reports_q, r};
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Append one byte to the buffer under construction
  task automatic append_byte(logic [7:0] b);
    buf_bytes = {buf_bytes, b};
  endtask

  // Queue the bytes in buf_bytes as one buffer; the last one may close the picture
  task automatic put_buffer(bit closes_picture);
    item_t it;
    for (int i = 0; i < buf_bytes.size(); i++) begin
      it.data_byte   = buf_bytes[i];
      it.picture_end = closes_picture && (i == buf_bytes.size() - 1);
      it.buffer_end  = (i == buf_bytes.size() - 1) &&
                       (!closes_picture || $urandom_range(0, 1) == 1);
      byte_q = {byte_q, it};
    end
  endtask

  // Mostly well-formed buffers of start codes, headers and payload; some pure noise
  task automatic fill_random_buffer();
    logic [TYPE_BITS-1:0] kind;
    buf_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 14))
        append_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) append_byte(8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 7) == 0) begin
          // three-byte code, not a start code for this scanner
          append_byte(8'($urandom_range(1, 255)));
        end else begin
          append_byte(8'h00);
        end
        append_byte(8'h00);
        append_byte(8'h00);
        append_byte(8'h01);
        case ($urandom_range(0, 5))
          0:       kind = TYPE_VPS;
          1:       kind = TYPE_SPS;
          2:       kind = TYPE_PPS;
          3:       kind = TYPE_IDR;
          4:       kind = TYPE_TRAIL;
          default: kind = TYPE_BITS'($urandom_range(0, 63));
        endcase
        append_byte({1'($urandom_range(0, 1)), kind, 1'($urandom_range(0, 1))});
        repeat ($urandom_range(0, 8))
          append_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
      end
      // start code landing on the buffer's final byte
      if ($urandom_range(0, 7) == 0) begin
        append_byte(8'h00);
        append_byte(8'h00);
        append_byte(8'h00);
        append_byte(8'h01);
      end
    end
  endtask

  task automatic random_picture();
    int unsigned nbuf;
    nbuf = $urandom_range(1, 4);
    for (int k = 0; k < nbuf; k++) begin
      fill_random_buffer();
      put_buffer(k == nbuf - 1);
    end
  endtask

  // Sender: offers queued bytes, idles now and then, predicts on each accepted request
  always @(posedge clk_i or negedge rst_ni) begin : driver
    bit    send;
    item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        scan_byte(item_t'{picture_end: s_axis_tlast, buffer_end: s_axis_tuser[0],
                          data_byte: s_axis_tdata});
      if (!s_axis_tvalid || s_axis_tready) begin
        send = byte_q.size() != 0 &&
               !($urandom_range(0, 99) < 10 && !(cyc >= 800 && cyc < 1200));
        if (send) begin
          nxt = byte_q.pop_front();
          s_axis_tdata <= nxt.data_byte;
          s_axis_tuser <= nxt.buffer_end;
          s_axis_tlast <= nxt.picture_end;
        end
        s_axis_tvalid <= send;
      end
    end
  end

  // Receiver: checks each accepted result; one long hold-off fills the block
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    int unsigned hold_cnt;
    bit          hold_used;
    result_t     want;
    int unsigned next_hold;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt      = 0;
      hold_used     = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        reports_seen++;
        if (unit_reports_q.size() == 0) begin
          $error("unit report with no expectation waiting: tdata 0x%0h tuser 0x%0h",
                 m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = unit_reports_q.pop_front();
          check_field("unit_class", want.unit_class, m_axis_tuser[2:0]);
          check_field("unit_type", want.unit_type, m_axis_tdata[5:0]);
          check_field("buffer_number", want.buffer_number, m_axis_tdata[13:6]);
          check_field("unit_offset", want.unit_offset, m_axis_tdata[37:14]);
          check_field("unit_length", want.unit_length, m_axis_tdata[62:38]);
          check_field("slice_bytes", want.slice_bytes, m_axis_tdata[94:63]);
          check_field("length_prefix", want.length_prefix, m_axis_tdata[126:95]);
          check_field("picture_done", want.picture_done, m_axis_tlast);
          check_field("no_slice_error", want.no_slice_error, m_axis_tuser[3]);
        end
      end
      next_hold = hold_cnt;
      if (hold_cnt != 0) begin
        next_hold = hold_cnt - 1;
      end else if (!hold_used && reports_seen >= 40) begin
        next_hold = 150;
        hold_used = 1'b1;
      end
      hold_cnt = next_hold;
      m_axis_tready <= (next_hold == 0) &&
                       !($urandom_range(0, 99) < 10 && !(cyc >= 800 && cyc < 1200));
    end
  end

  initial begin
    // Directed: leading byte, type 0x3f header, start code on the final byte
    buf_bytes = '{8'hAA, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01};
    put_buffer(1'b0);
    // picture end alone on a one-byte buffer, no unit open, no slices
    byte_q = {byte_q, item_t'{picture_end: 1'b1, buffer_end: 1'b0, data_byte: 8'h00}};
    // IDR stops the scan, later start codes in the buffer are payload
    buf_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h26, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
    put_buffer(1'b0);
    // trailing slice with bit 7 set in the header; closes unit and picture together
    buf_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h83};
    put_buffer(1'b1);

    // Random pictures
    while (byte_q.size() < 1150) random_picture();

    // Many buffers in one picture so the buffer index saturates
    repeat (257) begin
      buf_bytes = '{8'($urandom_range(0, 255))};
      put_buffer(1'b0);
    end
    buf_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h26, 8'($urandom_range(0, 255))};
    put_buffer(1'b1);
    while (byte_q.size() < 1450) random_picture();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((byte_q.size() != 0 || s_axis_tvalid || unit_reports_q.size() != 0) &&
           cyc < CYCLE_LIMIT)
      @(posedge clk_i);

    if (cyc >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
    end else begin
      repeat (10) @(posedge clk_i);
      if (mismatches == 0)
        $display("RESULT: OK");
      else
        $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
